// ===== src/rpnsc_pkg.sv =====
// Shared constants, command and status codes for the RPN stack calculator.
// No dependencies; the interfaces and the top level import this package.
package rpnsc_pkg;

  localparam int NODE_DEPTH    = 1024;
  localparam int HISTORY_DEPTH = 256;
  localparam int FRACTION_BITS = 16;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;
  localparam int DEPTH_W  = 11;

  localparam int NODE_AW  = $clog2(NODE_DEPTH);
  localparam int CNT_W    = NODE_AW + 1;
  localparam int HIST_AW  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W   = HIST_AW + 1;
  localparam int NODE_W   = DATA_W + NODE_AW;
  localparam int HIST_W   = NODE_AW + CNT_W;

  localparam int DIV_W     = DATA_W + FRACTION_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam cmd_t CMD_PUSH = 3'd0;
  localparam cmd_t CMD_ADD  = 3'd1;
  localparam cmd_t CMD_SUB  = 3'd2;
  localparam cmd_t CMD_MUL  = 3'd3;
  localparam cmd_t CMD_DIV  = 3'd4;
  localparam cmd_t CMD_SWAP = 3'd5;
  localparam cmd_t CMD_DROP = 3'd6;
  localparam cmd_t CMD_UNDO = 3'd7;

  localparam stat_t ST_OK        = 3'd0;
  localparam stat_t ST_UNDERFLOW = 3'd1;
  localparam stat_t ST_NO_UNDO   = 3'd2;
  localparam stat_t ST_FULL      = 3'd3;
  localparam stat_t ST_SAT       = 3'd4;
  localparam stat_t ST_EMPTY     = 3'd5;

endpackage

// ===== src/rpnsc_in_if.sv =====
// Command channel: valid/ready handshake with command and operand payload.
// Depends on rpnsc_pkg.
interface rpnsc_in_if;
  import rpnsc_pkg::*;
  logic              valid;
  logic              ready;
  cmd_t              command;
  logic signed [DATA_W-1:0] operand;
  modport source (output valid, command, operand, input ready);
  modport sink   (input valid, command, operand, output ready);
endinterface

// ===== src/rpnsc_out_if.sv =====
// Result channel: valid/ready handshake with top value, status and depth.
// Depends on rpnsc_pkg.
interface rpnsc_out_if;
  import rpnsc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  stat_t                    status;
  logic [DEPTH_W-1:0]       stack_depth;
  modport source (output valid, top_value, status, stack_depth, input ready);
  modport sink   (input valid, top_value, status, stack_depth, output ready);
endinterface

// ===== src/rpnsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpnsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rpn_stack_calculator_with_undo.sv =====
// RPN stack calculator with undo: top level, sequencer and arithmetic.
// Depends on rpnsc_pkg, rpnsc_in_if, rpnsc_out_if and rpnsc_ram.
//
// One command is taken per transfer and gives exactly one result transfer.
// The stack lives in a node RAM (value, link) that only grows, and every
// recorded command stores (head, count) in a history RAM, so undo just
// restores an earlier snapshot. Commands run one at a time through a small
// sequencer around these two RAMs with registered reads; divide uses a
// restoring divider on Q15.16 values that retires one quotient bit per cycle.
// The result register frees the sequencer: a new command is taken while
// the previous result still waits for its transfer. No clearing pass is
// needed after reset; only written entries are ever read.
module rpn_stack_calculator_with_undo (
  input logic clk,
  input logic rst_n,
  rpnsc_in_if.sink    in_chan,
  rpnsc_out_if.source out_chan
);
  import rpnsc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_UNDO_H = 4'd2;
  localparam logic [3:0] S_UNDO_N = 4'd3;
  localparam logic [3:0] S_RD_B   = 4'd4;
  localparam logic [3:0] S_RD_A   = 4'd5;
  localparam logic [3:0] S_EXEC   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_DIVFIN = 4'd9;
  localparam logic [3:0] S_WRITE  = 4'd10;
  localparam logic [3:0] S_SWAP2  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // control state
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  nfree_r, nfree_nxt;
  logic [NODE_AW-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload / datapath
  cmd_t               cmd_r, cmd_nxt;
  logic [DATA_W-1:0]  opnd_r, opnd_nxt;
  logic [DATA_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [NODE_AW-1:0] second_r, second_nxt, rest_r, rest_nxt;
  logic [DATA_W-1:0]  res_r, res_nxt;
  logic               sat_r, sat_nxt;
  logic signed [2*DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]   dvd_r, dvd_nxt;
  logic [DATA_W-1:0]  ub_r, ub_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic               neg_r, neg_nxt;
  logic [DATA_W-1:0]  fin_top_r, fin_top_nxt;
  stat_t              fin_st_r, fin_st_nxt;
  logic [DATA_W-1:0]  out_top_r, out_top_nxt;
  stat_t              out_st_r, out_st_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;

  // RAM ports
  logic               node_we;
  logic [NODE_AW-1:0] node_waddr, node_raddr;
  logic [NODE_W-1:0]  node_wdata, node_rdata;
  logic               hist_we;
  logic [HIST_AW-1:0] hist_waddr, hist_raddr;
  logic [HIST_W-1:0]  hist_wdata, hist_rdata;

  logic [DATA_W-1:0]  rd_value;
  logic [NODE_AW-1:0] rd_link;
  logic [NODE_AW-1:0] h_head;
  logic [CNT_W-1:0]   h_count;

  // arithmetic helpers
  logic [DATA_W:0]            sum_ext;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic [DATA_W:0]            trial;
  logic                       trial_ge;
  logic [DATA_W-1:0]          ua;

  rpnsc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  rpnsc_ram #(.WIDTH(HIST_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign rd_value = node_rdata[NODE_W-1 -: DATA_W];
  assign rd_link  = node_rdata[NODE_AW-1:0];
  assign h_head   = hist_rdata[HIST_W-1 -: NODE_AW];
  assign h_count  = hist_rdata[CNT_W-1:0];

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.top_value   = out_top_r;
  assign out_chan.status      = out_st_r;
  assign out_chan.stack_depth = out_depth_r;

  // add/sub: one extra bit catches overflow
  always_comb begin
    if (cmd_r == CMD_SUB) begin
      sum_ext = {a_r[DATA_W-1], a_r} - {b_r[DATA_W-1], b_r};
    end else begin
      sum_ext = {a_r[DATA_W-1], a_r} + {b_r[DATA_W-1], b_r};
    end
  end

  // floor shift of the registered product
  assign prod_sh = prod_r >>> FRACTION_BITS;

  // one restoring-division step
  assign trial    = {rem_r, dvd_r[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, ub_r});
  assign ua       = a_r[DATA_W-1] ? (~a_r + 1'b1) : a_r;

  always_comb begin
    state_nxt     = state_r;
    nfree_nxt     = nfree_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    opnd_nxt      = opnd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    second_nxt    = second_r;
    rest_nxt      = rest_r;
    res_nxt       = res_r;
    sat_nxt       = sat_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    ub_nxt        = ub_r;
    dcnt_nxt      = dcnt_r;
    neg_nxt       = neg_r;
    fin_top_nxt   = fin_top_r;
    fin_st_nxt    = fin_st_r;
    out_top_nxt   = out_top_r;
    out_st_nxt    = out_st_r;
    out_depth_nxt = out_depth_r;

    node_we    = 1'b0;
    node_waddr = nfree_r[NODE_AW-1:0];
    node_wdata = {opnd_r, head_r};
    node_raddr = head_r;
    hist_we    = 1'b0;
    hist_waddr = fill_r[HIST_AW-1:0];
    hist_wdata = {head_r, count_r};
    hist_raddr = HIST_AW'(fill_r - FILL_W'(2));

    // drop the result on its transfer
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt   = in_chan.command;
          opnd_nxt  = in_chan.operand;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        fin_top_nxt = '0;
        state_nxt   = S_DONE;
        if (cmd_r == CMD_UNDO) begin
          if (fill_r == '0) begin
            fin_st_nxt = ST_NO_UNDO;
          end else if (fill_r == FILL_W'(1)) begin
            fill_nxt   = '0;
            head_nxt   = '0;
            count_nxt  = '0;
            fin_st_nxt = ST_EMPTY;
          end else begin
            fill_nxt  = fill_r - 1'b1;
            state_nxt = S_UNDO_H;
          end
        end else if (fill_r == FILL_W'(HISTORY_DEPTH)) begin
          fin_st_nxt = ST_FULL;
        end else if (cmd_r == CMD_PUSH) begin
          if (nfree_r == CNT_W'(NODE_DEPTH)) begin
            fin_st_nxt = ST_FULL;
          end else begin
            node_we     = 1'b1;
            hist_we     = 1'b1;
            hist_wdata  = {nfree_r[NODE_AW-1:0], CNT_W'(count_r + 1'b1)};
            head_nxt    = nfree_r[NODE_AW-1:0];
            count_nxt   = count_r + 1'b1;
            nfree_nxt   = nfree_r + 1'b1;
            fill_nxt    = fill_r + 1'b1;
            fin_top_nxt = opnd_r;
            fin_st_nxt  = ST_OK;
          end
        end else if (count_r < CNT_W'(2)) begin
          // underflow still records the unchanged snapshot
          hist_we    = 1'b1;
          fill_nxt   = fill_r + 1'b1;
          fin_st_nxt = ST_UNDERFLOW;
        end else begin
          state_nxt = S_RD_B;
        end
      end

      S_UNDO_H: begin
        head_nxt  = h_head;
        count_nxt = h_count;
        if (h_count == '0) begin
          fin_top_nxt = '0;
          fin_st_nxt  = ST_EMPTY;
          state_nxt   = S_DONE;
        end else begin
          node_raddr = h_head;
          state_nxt  = S_UNDO_N;
        end
      end

      S_UNDO_N: begin
        fin_top_nxt = rd_value;
        fin_st_nxt  = ST_OK;
        state_nxt   = S_DONE;
      end

      S_RD_B: begin
        b_nxt      = rd_value;
        second_nxt = rd_link;
        node_raddr = rd_link;
        state_nxt  = S_RD_A;
      end

      S_RD_A: begin
        a_nxt     = rd_value;
        rest_nxt  = rd_link;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        sat_nxt = 1'b0;
        if (cmd_r == CMD_DROP) begin
          head_nxt    = second_r;
          count_nxt   = count_r - 1'b1;
          hist_we     = 1'b1;
          hist_wdata  = {second_r, CNT_W'(count_r - 1'b1)};
          fill_nxt    = fill_r + 1'b1;
          fin_top_nxt = a_r;
          fin_st_nxt  = ST_OK;
          state_nxt   = S_DONE;
        end else if (cmd_r == CMD_SWAP) begin
          if (nfree_r > CNT_W'(NODE_DEPTH - 2)) begin
            fin_top_nxt = '0;
            fin_st_nxt  = ST_FULL;
            state_nxt   = S_DONE;
          end else begin
            node_we    = 1'b1;
            node_wdata = {b_r, rest_r};
            state_nxt  = S_SWAP2;
          end
        end else if (nfree_r == CNT_W'(NODE_DEPTH)) begin
          fin_top_nxt = '0;
          fin_st_nxt  = ST_FULL;
          state_nxt   = S_DONE;
        end else if (cmd_r == CMD_MUL) begin
          prod_nxt  = $signed(a_r) * $signed(b_r);
          state_nxt = S_MUL;
        end else if (cmd_r == CMD_DIV) begin
          if (b_r == '0) begin
            sat_nxt = 1'b1;
            if (a_r == '0) begin
              res_nxt = '0;
            end else if (a_r[DATA_W-1]) begin
              res_nxt = VAL_MIN;
            end else begin
              res_nxt = VAL_MAX;
            end
            state_nxt = S_WRITE;
          end else begin
            neg_nxt   = a_r[DATA_W-1] ^ b_r[DATA_W-1];
            ub_nxt    = b_r[DATA_W-1] ? (~b_r + 1'b1) : b_r;
            dvd_nxt   = DIV_W'({ua, {FRACTION_BITS{1'b0}}});
            rem_nxt   = '0;
            dcnt_nxt  = DIV_CNT_W'(DIV_W);
            state_nxt = S_DIV;
          end
        end else begin
          // add or subtract
          if (sum_ext[DATA_W] != sum_ext[DATA_W-1]) begin
            sat_nxt = 1'b1;
            res_nxt = sum_ext[DATA_W] ? VAL_MIN : VAL_MAX;
          end else begin
            res_nxt = sum_ext[DATA_W-1:0];
          end
          state_nxt = S_WRITE;
        end
      end

      S_MUL: begin
        if (prod_sh > $signed({{DATA_W{1'b0}}, VAL_MAX})) begin
          sat_nxt = 1'b1;
          res_nxt = VAL_MAX;
        end else if (prod_sh < $signed({{DATA_W{1'b1}}, VAL_MIN})) begin
          sat_nxt = 1'b1;
          res_nxt = VAL_MIN;
        end else begin
          res_nxt = prod_sh[DATA_W-1:0];
        end
        state_nxt = S_WRITE;
      end

      S_DIV: begin
        if (trial_ge) begin
          rem_nxt = DATA_W'(trial - {1'b0, ub_r});
        end else begin
          rem_nxt = trial[DATA_W-1:0];
        end
        dvd_nxt  = {dvd_r[DIV_W-2:0], trial_ge};
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == DIV_CNT_W'(1)) begin
          state_nxt = S_DIVFIN;
        end
      end

      S_DIVFIN: begin
        if (neg_r) begin
          if (dvd_r > DIV_W'(VAL_MIN)) begin
            sat_nxt = 1'b1;
            res_nxt = VAL_MIN;
          end else begin
            res_nxt = ~dvd_r[DATA_W-1:0] + 1'b1;
          end
        end else if (dvd_r > DIV_W'(VAL_MAX)) begin
          sat_nxt = 1'b1;
          res_nxt = VAL_MAX;
        end else begin
          res_nxt = dvd_r[DATA_W-1:0];
        end
        state_nxt = S_WRITE;
      end

      S_WRITE: begin
        node_we     = 1'b1;
        node_wdata  = {res_r, rest_r};
        head_nxt    = nfree_r[NODE_AW-1:0];
        count_nxt   = count_r - 1'b1;
        nfree_nxt   = nfree_r + 1'b1;
        hist_we     = 1'b1;
        hist_wdata  = {nfree_r[NODE_AW-1:0], CNT_W'(count_r - 1'b1)};
        fill_nxt    = fill_r + 1'b1;
        fin_top_nxt = res_r;
        fin_st_nxt  = sat_r ? ST_SAT : ST_OK;
        state_nxt   = S_DONE;
      end

      S_SWAP2: begin
        // old second goes on top, linked to the node written last cycle
        node_we     = 1'b1;
        node_waddr  = NODE_AW'(nfree_r + 1'b1);
        node_wdata  = {a_r, nfree_r[NODE_AW-1:0]};
        head_nxt    = NODE_AW'(nfree_r + 1'b1);
        nfree_nxt   = nfree_r + CNT_W'(2);
        hist_we     = 1'b1;
        hist_wdata  = {NODE_AW'(nfree_r + 1'b1), count_r};
        fill_nxt    = fill_r + 1'b1;
        fin_top_nxt = a_r;
        fin_st_nxt  = ST_OK;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_top_nxt   = fin_top_r;
          out_st_nxt    = fin_st_r;
          out_depth_nxt = DEPTH_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nfree_r     <= '0;
      head_r      <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nfree_r     <= nfree_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    opnd_r      <= opnd_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    second_r    <= second_nxt;
    rest_r      <= rest_nxt;
    res_r       <= res_nxt;
    sat_r       <= sat_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    ub_r        <= ub_nxt;
    dcnt_r      <= dcnt_nxt;
    neg_r       <= neg_nxt;
    fin_top_r   <= fin_top_nxt;
    fin_st_r    <= fin_st_nxt;
    out_top_r   <= out_top_nxt;
    out_st_r    <= out_st_nxt;
    out_depth_r <= out_depth_nxt;
  end

endmodule
